// ----- hdl/crtl_pkg.sv -----
// Package for the code range table: table geometry, operation and status
// codes, and the entry and write-request types shared by the top level and
// the table memory. No dependencies.
package crtl_pkg;

    localparam int unsigned MAX_ENTRIES = 1024;
    localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SLOT_W      = 10;
    localparam int unsigned OFS_W       = 32;
    localparam int unsigned ADDR_W      = 64;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [OFS_W-1:0]  ofs_t;

    localparam cnt_t MAX_CNT  = cnt_t'(MAX_ENTRIES);
    localparam idx_t LAST_IDX = idx_t'(MAX_ENTRIES - 1);

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_FILL    = 2'd1,
        OP_LOOKUP  = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_e;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_e;

    typedef struct packed {
        ofs_t begin_ofs;
        ofs_t end_ofs;
        ofs_t unwind_ofs;
    } entry_t;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t entry;
    } tbl_wr_t;

    typedef struct packed {
        logic [1:0] status;
        slot_t      slot;
        ofs_t       begin_ofs;
        ofs_t       unwind_ofs;
    } result_t;

endpackage

// ----- hdl/crtl_table.sv -----
// Range table memory: one entry (begin, end, unwind offsets) per slot,
// one write port and one read port with registered read data.
// Depends on crtl_pkg.
module crtl_table (
    input  logic                 aclk,
    input  crtl_pkg::tbl_wr_t    wr,
    input  crtl_pkg::idx_t       rd_addr,
    output crtl_pkg::entry_t     rd_data
);

    crtl_pkg::entry_t mem [crtl_pkg::MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.entry;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/code_range_table_lookup.sv -----
// Top level of the code range table: reserve, fill and lookup control,
// configuration register and result register around the table memory.
// Depends on crtl_pkg and crtl_table.

// The block keeps up to 1024 code ranges, each a begin, end and unwind
// offset relative to code_base, in one synchronous table memory. After
// reset a clearing pass writes zero into every slot, one slot per cycle;
// s_ready stays low during that pass, while writes to code_base are taken
// at any time. One item is worked on at a time. A reserve, a fill or an
// unused operation code is handled in the EXEC state; its result is
// registered on entry to DONE and moves to the output register once that
// is free. A lookup issues its first probe on acceptance and then makes
// one probe of the binary search per cycle in EXEC, and a full table
// needs up to 11 probes: the search makes one table read per cycle, the
// next probe address being formed from the compare of the current one.
// The next item can be accepted once the result is in the output
// register, even while that finished result still waits on the m_ side.
module code_range_table_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: code_base.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    // Input items.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [9:0]  s_slot,
    input  logic [63:0] s_address,
    input  logic [63:0] s_unwind_address,
    input  logic [31:0] s_code_length,
    // Result items.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_slot_out,
    output logic [31:0] m_begin_offset,
    output logic [31:0] m_unwind_offset
);

    crtl_pkg::state_e  state_reg, state_next;
    crtl_pkg::cnt_t    entries_reg, entries_next;
    crtl_pkg::idx_t    clear_cnt_reg, clear_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       code_base_reg;

    // Search bounds; mid_reg names the slot whose entry the table returns.
    crtl_pkg::cnt_t    lo_reg, lo_next;
    crtl_pkg::cnt_t    hi_reg, hi_next;
    crtl_pkg::cnt_t    mid_reg, mid_next;

    // Captured item and the pending result.
    logic [1:0]        op_reg;
    crtl_pkg::slot_t   slot_reg;
    crtl_pkg::ofs_t    key_reg;
    crtl_pkg::ofs_t    unwind_ofs_reg;
    crtl_pkg::ofs_t    length_reg;
    crtl_pkg::result_t res_reg, res_next;
    crtl_pkg::result_t out_reg, out_next;

    crtl_pkg::tbl_wr_t wr;
    crtl_pkg::idx_t    rd_addr;
    crtl_pkg::entry_t  rd_data;

    logic              accept;
    crtl_pkg::cnt_t    lo_srch, hi_srch, mid_srch;

    crtl_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == crtl_pkg::S_IDLE);
    assign accept    = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_slot_out      = out_reg.slot;
    assign m_begin_offset  = out_reg.begin_ofs;
    assign m_unwind_offset = out_reg.unwind_ofs;

    // One binary-search step on the entry read for mid_reg. The new bounds
    // also give the next probe address, so a probe completes every cycle.
    always_comb begin
        lo_srch = lo_reg;
        hi_srch = hi_reg;
        if (key_reg < rd_data.begin_ofs) begin
            hi_srch = mid_reg;
        end else if (key_reg >= rd_data.end_ofs) begin
            lo_srch = mid_reg + crtl_pkg::cnt_t'(1);
        end
        mid_srch = lo_srch + ((hi_srch - lo_srch) >> 1);
    end

    always_comb begin
        state_next     = state_reg;
        entries_next   = entries_reg;
        clear_cnt_next = clear_cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg;
        wr             = '0;
        rd_addr        = crtl_pkg::idx_t'(mid_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            crtl_pkg::S_CLEAR: begin
                wr.en          = 1'b1;
                wr.addr        = clear_cnt_reg;
                clear_cnt_next = clear_cnt_reg + crtl_pkg::idx_t'(1);
                if (clear_cnt_reg == crtl_pkg::LAST_IDX) begin
                    state_next = crtl_pkg::S_IDLE;
                end
            end
            crtl_pkg::S_IDLE: begin
                // The first probe is issued on acceptance; lo starts at zero.
                rd_addr = crtl_pkg::idx_t'(entries_reg >> 1);
                if (accept) begin
                    lo_next    = '0;
                    hi_next    = entries_reg;
                    mid_next   = entries_reg >> 1;
                    state_next = crtl_pkg::S_EXEC;
                end
            end
            crtl_pkg::S_EXEC: begin
                res_next = '0;
                case (op_reg)
                    crtl_pkg::OP_RESERVE: begin
                        if (entries_reg >= crtl_pkg::MAX_CNT) begin
                            res_next.status = crtl_pkg::ST_FULL;
                        end else begin
                            res_next.slot = crtl_pkg::slot_t'(entries_reg);
                            entries_next  = entries_reg + crtl_pkg::cnt_t'(1);
                        end
                        state_next = crtl_pkg::S_DONE;
                    end
                    crtl_pkg::OP_FILL: begin
                        if (crtl_pkg::cnt_t'(slot_reg) < crtl_pkg::MAX_CNT) begin
                            wr.en               = 1'b1;
                            wr.addr             = crtl_pkg::idx_t'(slot_reg);
                            wr.entry.begin_ofs  = key_reg;
                            wr.entry.end_ofs    = key_reg + length_reg;
                            wr.entry.unwind_ofs = unwind_ofs_reg;
                        end
                        state_next = crtl_pkg::S_DONE;
                    end
                    crtl_pkg::OP_LOOKUP: begin
                        if (lo_reg >= hi_reg) begin
                            // Empty table: nothing to probe.
                            res_next.status = crtl_pkg::ST_NOT_FOUND;
                            state_next      = crtl_pkg::S_DONE;
                        end else if (key_reg >= rd_data.begin_ofs &&
                                     key_reg < rd_data.end_ofs) begin
                            res_next.slot       = crtl_pkg::slot_t'(mid_reg);
                            res_next.begin_ofs  = rd_data.begin_ofs;
                            res_next.unwind_ofs = rd_data.unwind_ofs;
                            state_next          = crtl_pkg::S_DONE;
                        end else begin
                            lo_next  = lo_srch;
                            hi_next  = hi_srch;
                            mid_next = mid_srch;
                            rd_addr  = crtl_pkg::idx_t'(mid_srch);
                            if (lo_srch >= hi_srch) begin
                                res_next.status = crtl_pkg::ST_NOT_FOUND;
                                state_next      = crtl_pkg::S_DONE;
                            end
                        end
                    end
                    default: begin
                        state_next = crtl_pkg::S_DONE;
                    end
                endcase
            end
            crtl_pkg::S_DONE: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = crtl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = crtl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= crtl_pkg::S_CLEAR;
            entries_reg   <= '0;
            clear_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
            code_base_reg <= '0;
        end else begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            clear_cnt_reg <= clear_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                code_base_reg <= cfg_data;
            end
        end
    end

    // Offsets wrap at 32 bits, so only the low halves of the subtraction
    // matter.
    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
        out_reg <= out_next;
        if (accept) begin
            op_reg         <= s_operation;
            slot_reg       <= s_slot;
            key_reg        <= s_address[31:0] - code_base_reg[31:0];
            unwind_ofs_reg <= s_unwind_address[31:0] - code_base_reg[31:0];
            length_reg     <= s_code_length;
        end
    end

    // The slot counter never passes the table capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        entries_reg <= crtl_pkg::MAX_CNT)
        else $error("slot counter beyond table capacity");

    // Search bounds stay ordered and inside the slots in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crtl_pkg::S_EXEC && op_reg == crtl_pkg::OP_LOOKUP)
        |-> (lo_reg <= hi_reg && hi_reg <= entries_reg &&
             (lo_reg == hi_reg || (mid_reg >= lo_reg && mid_reg < hi_reg))))
        else $error("search bounds out of order");

    // A new result appears only after the result step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == crtl_pkg::S_DONE))
        else $error("result without completed item");

    // The table is only written by the clearing pass or a fill.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == crtl_pkg::S_CLEAR ||
                   (state_reg == crtl_pkg::S_EXEC && op_reg == crtl_pkg::OP_FILL)))
        else $error("unexpected table write");

    // A miss never reports slot or offsets.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status == crtl_pkg::ST_NOT_FOUND)
        |-> (out_reg.slot == '0 && out_reg.begin_ofs == '0 &&
             out_reg.unwind_ofs == '0))
        else $error("not-found result carries data");

endmodule
